>>> rtl/core/lmts_pkg.sv
// Shared types, constants and the font table for the LED matrix text scroller.
package lmts_pkg;

    localparam int NROWS = 5;
    localparam int NCOLS = 16;
    localparam int DEFAULT_TEXT_DEPTH = 64;
    localparam logic [15:0] PERIOD_RESET = 16'd50;
    localparam logic [2:0] GAP_COL = 3'd5;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_SET = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_APPEND = 2'd3;

    localparam logic CFG_PERIOD = 1'b0;
    localparam logic CFG_LOWCOL = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic apply;      // item in the input register takes effect
        logic scroll;     // perform one scroll pass
        logic emit;       // load the result register
        logic done;       // the result register is complete and may be offered
    } lmts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic step_due;   // this tick reaches the scroll period
        logic skip;       // the last scroll pass skipped a gap column
    } lmts_stat_t;

    function automatic logic [24:0] glyph_bits(input logic [6:0] gi);
        logic [24:0] g;
        unique case (gi)
            7'd0: g = {5'h00,5'h00,5'h00,5'h00,5'h00};
            7'd1: g = {5'h00,5'h00,5'h17,5'h00,5'h00};
            7'd2: g = {5'h00,5'h03,5'h04,5'h03,5'h04};
            7'd3: g = {5'h0A,5'h1F,5'h0A,5'h1F,5'h0A};
            7'd4: g = {5'h09,5'h15,5'h1F,5'h15,5'h12};
            7'd5: g = {5'h19,5'h1A,5'h04,5'h0B,5'h13};
            7'd6: g = {5'h18,5'h08,5'h17,5'h15,5'h0A};
            7'd7: g = {5'h00,5'h00,5'h03,5'h04,5'h00};
            7'd8: g = {5'h00,5'h00,5'h11,5'h0E,5'h00};
            7'd9: g = {5'h00,5'h00,5'h0E,5'h11,5'h00};
            7'd10: g = {5'h0A,5'h04,5'h1F,5'h04,5'h0A};
            7'd11: g = {5'h00,5'h04,5'h0E,5'h04,5'h00};
            7'd12: g = {5'h00,5'h00,5'h08,5'h10,5'h00};
            7'd13: g = {5'h00,5'h04,5'h04,5'h04,5'h00};
            7'd14: g = {5'h00,5'h00,5'h10,5'h00,5'h00};
            7'd15: g = {5'h01,5'h02,5'h04,5'h08,5'h10};
            7'd16: g = {5'h00,5'h0E,5'h15,5'h19,5'h0E};
            7'd17: g = {5'h00,5'h10,5'h1F,5'h12,5'h00};
            7'd18: g = {5'h00,5'h12,5'h15,5'h15,5'h19};
            7'd19: g = {5'h00,5'h0A,5'h15,5'h15,5'h11};
            7'd20: g = {5'h00,5'h08,5'h1F,5'h0A,5'h0C};
            7'd21: g = {5'h00,5'h09,5'h15,5'h15,5'h13};
            7'd22: g = {5'h00,5'h08,5'h15,5'h15,5'h0E};
            7'd23: g = {5'h00,5'h03,5'h05,5'h19,5'h01};
            7'd24: g = {5'h00,5'h0A,5'h15,5'h15,5'h0A};
            7'd25: g = {5'h00,5'h1E,5'h15,5'h15,5'h02};
            7'd26: g = {5'h00,5'h00,5'h0A,5'h00,5'h00};
            7'd27: g = {5'h00,5'h00,5'h0A,5'h10,5'h00};
            7'd28: g = {5'h00,5'h11,5'h0A,5'h04,5'h00};
            7'd29: g = {5'h00,5'h0A,5'h0A,5'h0A,5'h00};
            7'd30: g = {5'h00,5'h04,5'h0A,5'h11,5'h00};
            7'd31: g = {5'h02,5'h05,5'h15,5'h01,5'h02};
            7'd32: g = {5'h16,5'h15,5'h15,5'h11,5'h0E};
            7'd33: g = {5'h00,5'h1E,5'h05,5'h05,5'h1E};
            7'd34: g = {5'h00,5'h0A,5'h15,5'h15,5'h1F};
            7'd35: g = {5'h00,5'h11,5'h11,5'h11,5'h0E};
            7'd36: g = {5'h00,5'h0E,5'h11,5'h11,5'h1F};
            7'd37: g = {5'h00,5'h11,5'h15,5'h15,5'h1F};
            7'd38: g = {5'h00,5'h01,5'h05,5'h05,5'h1F};
            7'd39: g = {5'h00,5'h1C,5'h15,5'h11,5'h0E};
            7'd40: g = {5'h00,5'h1F,5'h04,5'h04,5'h1F};
            7'd41: g = {5'h00,5'h11,5'h1F,5'h11,5'h00};
            7'd42: g = {5'h00,5'h01,5'h0F,5'h11,5'h08};
            7'd43: g = {5'h00,5'h11,5'h0A,5'h04,5'h1F};
            7'd44: g = {5'h00,5'h10,5'h10,5'h10,5'h1F};
            7'd45: g = {5'h1F,5'h02,5'h04,5'h02,5'h1F};
            7'd46: g = {5'h00,5'h1F,5'h04,5'h02,5'h1F};
            7'd47: g = {5'h00,5'h0E,5'h11,5'h11,5'h0E};
            7'd48: g = {5'h00,5'h02,5'h05,5'h05,5'h1F};
            7'd49: g = {5'h00,5'h16,5'h09,5'h11,5'h0E};
            7'd50: g = {5'h00,5'h12,5'h0D,5'h05,5'h1F};
            7'd51: g = {5'h00,5'h09,5'h15,5'h15,5'h12};
            7'd52: g = {5'h01,5'h01,5'h1F,5'h01,5'h01};
            7'd53: g = {5'h00,5'h0F,5'h10,5'h10,5'h0F};
            7'd54: g = {5'h03,5'h0C,5'h10,5'h0C,5'h03};
            7'd55: g = {5'h1F,5'h08,5'h04,5'h08,5'h1F};
            7'd56: g = {5'h11,5'h0A,5'h04,5'h0A,5'h11};
            7'd57: g = {5'h01,5'h02,5'h1C,5'h02,5'h01};
            7'd58: g = {5'h11,5'h13,5'h15,5'h19,5'h11};
            7'd59: g = {5'h00,5'h11,5'h11,5'h1F,5'h00};
            7'd60: g = {5'h10,5'h08,5'h04,5'h02,5'h01};
            7'd61: g = {5'h00,5'h1F,5'h11,5'h11,5'h00};
            7'd62: g = {5'h00,5'h02,5'h01,5'h02,5'h00};
            7'd63: g = {5'h10,5'h10,5'h10,5'h10,5'h10};
            7'd64: g = {5'h00,5'h00,5'h04,5'h03,5'h00};
            7'd65: g = {5'h1E,5'h15,5'h15,5'h15,5'h08};
            7'd66: g = {5'h08,5'h14,5'h14,5'h14,5'h1F};
            7'd67: g = {5'h00,5'h12,5'h12,5'h12,5'h0C};
            7'd68: g = {5'h1F,5'h14,5'h14,5'h14,5'h08};
            7'd69: g = {5'h16,5'h15,5'h15,5'h15,5'h0E};
            7'd70: g = {5'h02,5'h01,5'h05,5'h1E,5'h04};
            7'd71: g = {5'h0E,5'h15,5'h15,5'h15,5'h12};
            7'd72: g = {5'h00,5'h18,5'h04,5'h04,5'h1F};
            7'd73: g = {5'h00,5'h00,5'h1D,5'h00,5'h00};
            7'd74: g = {5'h00,5'h00,5'h0D,5'h10,5'h00};
            7'd75: g = {5'h00,5'h11,5'h0A,5'h04,5'h1F};
            7'd76: g = {5'h00,5'h10,5'h1F,5'h11,5'h00};
            7'd77: g = {5'h1E,5'h01,5'h06,5'h01,5'h1E};
            7'd78: g = {5'h1E,5'h01,5'h01,5'h01,5'h1F};
            7'd79: g = {5'h00,5'h0E,5'h11,5'h11,5'h0E};
            7'd80: g = {5'h00,5'h02,5'h05,5'h05,5'h1F};
            7'd81: g = {5'h10,5'h1F,5'h05,5'h05,5'h02};
            7'd82: g = {5'h02,5'h01,5'h01,5'h02,5'h1F};
            7'd83: g = {5'h00,5'h09,5'h15,5'h15,5'h12};
            7'd84: g = {5'h00,5'h12,5'h12,5'h0F,5'h02};
            7'd85: g = {5'h00,5'h0F,5'h10,5'h10,5'h0F};
            7'd86: g = {5'h03,5'h0C,5'h10,5'h0C,5'h03};
            7'd87: g = {5'h0F,5'h10,5'h0C,5'h10,5'h0F};
            7'd88: g = {5'h11,5'h0A,5'h04,5'h0A,5'h11};
            7'd89: g = {5'h00,5'h0F,5'h14,5'h14,5'h13};
            7'd90: g = {5'h00,5'h12,5'h16,5'h1A,5'h12};
            7'd91: g = {5'h06,5'h0F,5'h1E,5'h0F,5'h06};
            7'd92: g = {5'h12,5'h08,5'h07,5'h08,5'h12};
            7'd93: g = {5'h04,5'h04,5'h15,5'h0E,5'h04};
            7'd94: g = {5'h1F,5'h1F,5'h1F,5'h1F,5'h1F};
            default: g = 25'd0;
        endcase
        return g;
    endfunction

endpackage

>>> rtl/core/lmts_ctrl.sv
// Controller: sequences accept, up to two scroll passes and the result load.
module lmts_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic                in_is_tick,
    input  logic                out_busy,
    input  lmts_pkg::lmts_stat_t stat,
    output logic                accept_ok,
    output lmts_pkg::lmts_cmd_t cmd
);
    import lmts_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_PASS2 = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       tick_reg, tick_next;

    assign accept_ok = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        tick_next = tick_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXEC;
                    tick_next = in_is_tick;
                end
            end
            S_EXEC:
            begin
                if (!out_busy)
                begin
                    cmd.apply = 1'b1;
                    cmd.emit = 1'b1;
                    cmd.scroll = tick_reg && stat.step_due;
                    // With a scroll step the result is offered only after the last pass.
                    cmd.done = !(tick_reg && stat.step_due);
                    state_next = (tick_reg && stat.step_due) ? S_PASS2 : S_IDLE;
                end
            end
            S_PASS2:
            begin
                // A second pass runs only when the first one skipped a gap.
                cmd.scroll = stat.skip;
                cmd.done = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tick_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tick_reg <= tick_next;
        end
    end
endmodule

>>> rtl/core/lmts_datapath.sv
// Datapath: bitmaps, scan and scroll counters, text queue and result register.
module lmts_datapath #(
    parameter int TEXT_DEPTH = lmts_pkg::DEFAULT_TEXT_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [1:0]          mode,
    input  logic [3:0]          row_pick,
    input  logic [4:0]          col_pick,
    input  logic [7:0]          char_in,
    input  logic                cfg_fire,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    input  lmts_pkg::lmts_cmd_t cmd,
    output lmts_pkg::lmts_stat_t stat,
    output logic [4:0]          row_select,
    output logic [15:0]         column_drive,
    output logic                low_byte_valid,
    output logic                text_empty,
    output logic                overflow
);
    import lmts_pkg::*;

    localparam int AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int CW = $clog2(TEXT_DEPTH + 1);

    logic [1:0]  mode_reg;
    logic [3:0]  row_reg;
    logic [4:0]  col_reg;
    logic [7:0]  char_reg;
    logic [15:0] period_reg;
    logic        lowcol_reg;
    logic [15:0] user_reg [NROWS];
    logic [15:0] scroll_reg [NROWS];
    logic [2:0]  scan_reg;
    logic [15:0] tick_reg;
    logic [2:0]  gcol_reg;
    logic        lit_reg;
    logic        skip_reg;
    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [7:0]  text_mem [TEXT_DEPTH];
    logic [7:0]  head_char_reg;
    logic [4:0]  rsel_reg;
    logic [15:0] drive_reg;
    logic        lbv_reg, empty_reg, ovf_reg;

    logic [2:0]  scan_next;
    logic [15:0] tick_inc;
    logic        is_tick, is_append, q_full, do_push, pop;
    logic [CW:0] tail_sum;
    logic [AW-1:0] tail_idx, head_inc;
    logic [7:0]  head_ch;
    logic [6:0]  gi;
    logic [24:0] glyph;
    logic [4:0]  gcolumn;
    logic        gap_skip;
    logic [15:0] row_mix;

    assign is_tick = (mode_reg == MODE_TICK);
    assign is_append = (mode_reg == MODE_APPEND) && (char_reg != 8'd0);
    assign q_full = (count_reg == CW'(TEXT_DEPTH));
    assign do_push = cmd.apply && is_append && !q_full;
    assign scan_next = (scan_reg == 3'(NROWS - 1)) ? 3'd0 : scan_reg + 3'd1;
    assign tick_inc = tick_reg + 16'd1;
    assign stat.step_due = (tick_inc == period_reg);
    assign stat.skip = skip_reg;
    assign tail_sum = (CW+1)'(head_reg) + (CW+1)'(count_reg);
    assign tail_idx = AW'((tail_sum >= (CW+1)'(TEXT_DEPTH))
                          ? tail_sum - (CW+1)'(TEXT_DEPTH) : tail_sum);
    assign head_inc = (head_reg == AW'(TEXT_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // The head character is read from the queue memory through a register.
    assign head_ch = (count_reg != '0) ? head_char_reg : 8'd0;
    assign gi = (head_ch >= 8'h20 && head_ch < 8'h7F) ? 7'(head_ch - 8'h20) : 7'd0;
    assign glyph = glyph_bits(gi);
    always_comb
    begin
        unique case (gcol_reg)
            3'd0: gcolumn = glyph[4:0];
            3'd1: gcolumn = glyph[9:5];
            3'd2: gcolumn = glyph[14:10];
            3'd3: gcolumn = glyph[19:15];
            3'd4: gcolumn = glyph[24:20];
            default: gcolumn = 5'd0;
        endcase
    end
    assign gap_skip = (gcol_reg >= GAP_COL) && !lit_reg;
    assign pop = cmd.scroll && (count_reg != '0) && (gcol_reg >= GAP_COL);
    assign row_mix = user_reg[scan_next] ^ scroll_reg[scan_next];

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg <= mode;
            row_reg <= row_pick;
            col_reg <= col_pick;
            char_reg <= char_in;
        end
        if (do_push)
            text_mem[tail_idx] <= char_reg;
        // A pop reads the new head so that a following pass sees the next character.
        head_char_reg <= text_mem[pop ? head_inc : head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            lowcol_reg <= 1'b1;
            for (int r = 0; r < NROWS; r++)
            begin
                user_reg[r] <= '0;
                scroll_reg[r] <= '0;
            end
            scan_reg <= '0;
            tick_reg <= '0;
            gcol_reg <= '0;
            lit_reg <= 1'b0;
            skip_reg <= 1'b0;
            head_reg <= '0;
            count_reg <= '0;
            rsel_reg <= '0;
            drive_reg <= 16'hFFFF;
            lbv_reg <= 1'b1;
            empty_reg <= 1'b1;
            ovf_reg <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                if (cfg_index == CFG_PERIOD)
                    period_reg <= cfg_data;
                else
                    lowcol_reg <= cfg_data[0];
            end
            if (cmd.apply && is_tick)
            begin
                scan_reg <= scan_next;
                tick_reg <= stat.step_due ? 16'd0 : tick_inc;
            end
            if (cmd.apply && (mode_reg == MODE_SET || mode_reg == MODE_CLEAR))
            begin
                for (int r = 0; r < NROWS; r++)
                    for (int c = 0; c < NCOLS; c++)
                        if ((row_reg == 4'hF || row_reg == 4'(r))
                            && (col_reg == 5'h1F || col_reg == 5'(c)))
                            user_reg[r][c] <= (mode_reg == MODE_SET);
            end
            if (cmd.scroll)
            begin
                skip_reg <= gap_skip;
                if (!gap_skip)
                begin
                    lit_reg <= (gcol_reg < GAP_COL) && (gcolumn != 5'd0);
                    for (int r = 0; r < NROWS; r++)
                        scroll_reg[r] <= {(gcol_reg < GAP_COL) && gcolumn[r],
                                          scroll_reg[r][15:1]};
                end
                if (count_reg != '0)
                    gcol_reg <= (gcol_reg >= GAP_COL) ? 3'd0 : gcol_reg + 3'd1;
                if (pop)
                    head_reg <= head_inc;
            end
            else
                skip_reg <= 1'b0;
            if (do_push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !do_push)
                count_reg <= count_reg - 1'b1;
            if (cmd.emit)
            begin
                rsel_reg <= is_tick ? 5'(1 << scan_next) : 5'd0;
                drive_reg <= is_tick ? (~row_mix | (lowcol_reg ? 16'h0000 : 16'h00FF))
                                     : 16'hFFFF;
                lbv_reg <= lowcol_reg;
                ovf_reg <= is_append && q_full;
                empty_reg <= pop ? (count_reg == CW'(1))
                                 : ((count_reg == '0) && !do_push);
            end
            else if (pop)
                empty_reg <= (count_reg == CW'(1));
        end
    end

    assign row_select = rsel_reg;
    assign column_drive = drive_reg;
    assign low_byte_valid = lbv_reg;
    assign text_empty = empty_reg;
    assign overflow = ovf_reg;
endmodule

>>> rtl/core/led_matrix_text_scroller_unit.sv
// Top level of the LED matrix text scroller.
// One transaction is accepted at a time. A set, clear or append item runs the execute
// state, which loads the result; a tick too, and on a due scroll step it also shifts one
// glyph column in a scroll pass, then runs another pass in the second-pass state if the
// first skipped a gap column. The next item is accepted once the controller is idle.
// The result register holds the item's result on the m_axis side, unchanged, until it
// is taken; an item waits for the previous result to be taken before it takes effect.
module led_matrix_text_scroller_unit #(
    parameter int TEXT_DEPTH = lmts_pkg::DEFAULT_TEXT_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // row_pick[3:0], col_pick[8:4], char_in[16:9], zeros
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // row_select[4:0], column_drive[20:5], zeros
    output logic [2:0]  m_axis_tuser,  // low_byte_valid[0], text_empty[1], overflow[2]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import lmts_pkg::*;

    lmts_cmd_t  cmd;
    lmts_stat_t stat;
    logic       accept_ok, in_fire, ovalid_reg;
    logic [4:0] rsel;
    logic [15:0] drive;
    logic       lbv, empty, ovf;

    assign s_axis_tready = accept_ok;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    lmts_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .in_is_tick(s_axis_tuser == MODE_TICK),
        .out_busy(ovalid_reg && !m_axis_tready),
        .stat(stat), .accept_ok(accept_ok), .cmd(cmd)
    );

    lmts_datapath #(.TEXT_DEPTH(TEXT_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .mode(s_axis_tuser),
        .row_pick(s_axis_tdata[3:0]), .col_pick(s_axis_tdata[8:4]),
        .char_in(s_axis_tdata[16:9]), .cfg_fire(cfg_valid && cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .stat(stat),
        .row_select(rsel), .column_drive(drive), .low_byte_valid(lbv),
        .text_empty(empty), .overflow(ovf)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.done)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {3'd0, drive, rsel};
    assign m_axis_tuser = {ovf, empty, lbv};
endmodule

>>> rtl/core/lmts_checker.sv
// Port-level checker for the LED matrix text scroller, bound to the top level.
module lmts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tdata[4:0]))
        else $error("row select not one-hot");
    a_dark: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[4:0] == 5'd0 |-> m_axis_tdata[20:5] == 16'hFFFF)
        else $error("non-tick result lit columns");
    a_noready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted two items back to back");
endmodule

bind led_matrix_text_scroller_unit lmts_checker u_lmts_checker (
    .clk(clk), .rst_n(rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready)
);

>>> bench/led_matrix_text_scroller_unit_tb.sv
// Self-checking testbench for the LED matrix text scroller with a built-in scan and scroll predictor.
module led_matrix_text_scroller_unit_tb;
    import lmts_pkg::*;

    localparam int QUEUE_DEPTH = 64;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [4:0]  row_select;
        logic [15:0] column_drive;
        logic        low_byte_valid;
        logic        text_empty;
        logic        overflow;
    } scan_result_t;

    // Font columns 0..4 of each printable character, column 0 in the top byte.
    localparam logic [39:0] FONT [96] = '{
        40'h0000000000, 40'h0000170000, 40'h0403040300, 40'h0A1F0A1F0A,
        40'h12151F1509, 40'h130B041A19, 40'h0A15170818, 40'h0004030000,
        40'h000E110000, 40'h00110E0000, 40'h0A041F040A, 40'h00040E0400,
        40'h0010080000, 40'h0004040400, 40'h0000100000, 40'h1008040201,
        40'h0E19150E00, 40'h00121F1000, 40'h1915151200, 40'h1115150A00,
        40'h0C0A1F0800, 40'h1315150900, 40'h0E15150800, 40'h0119050300,
        40'h0A15150A00, 40'h0215151E00, 40'h00000A0000, 40'h00100A0000,
        40'h00040A1100, 40'h000A0A0A00, 40'h00110A0400, 40'h0201150502,
        40'h0E11151516, 40'h1E05051E00, 40'h1F15150A00, 40'h0E11111100,
        40'h1F11110E00, 40'h1F15151100, 40'h1F05050100, 40'h0E11151C00,
        40'h1F04041F00, 40'h00111F1100, 40'h08110F0100, 40'h1F040A1100,
        40'h1F10101000, 40'h1F0204021F, 40'h1F02041F00, 40'h0E11110E00,
        40'h1F05050200, 40'h0E11091600, 40'h1F050D1200, 40'h1215150900,
        40'h01011F0101, 40'h0F10100F00, 40'h030C100C03, 40'h1F0804081F,
        40'h110A040A11, 40'h01021C0201, 40'h1119151311, 40'h001F111100,
        40'h0102040810, 40'h0011111F00, 40'h0002010200, 40'h1010101010,
        40'h0003040000, 40'h081515151E, 40'h1F14141408, 40'h0C12121200,
        40'h081414141F, 40'h0E15151516, 40'h041E050102, 40'h121515150E,
        40'h1F04041800, 40'h00001D0000, 40'h00100D0000, 40'h1F040A1100,
        40'h00111F1000, 40'h1E0106011E, 40'h1F0101011E, 40'h0E11110E00,
        40'h1F05050200, 40'h0205051F10, 40'h1F02010102, 40'h1215150900,
        40'h020F121200, 40'h0F10100F00, 40'h030C100C03, 40'h0F100C100F,
        40'h110A040A11, 40'h1314140F00, 40'h121A161200, 40'h060F1E0F06,
        40'h1208070812, 40'h040E150404, 40'h1F1F1F1F1F, 40'h0000000000
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    led_matrix_text_scroller_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Predictor state.
    logic [15:0] period_q;
    logic        low_cols_q;
    logic [15:0] user_rows [NROWS];
    logic [15:0] text_rows [NROWS];
    logic [2:0]  scan_q;
    logic [15:0] tick_q;
    logic [2:0]  glyph_col_q;
    logic        col_lit_q;
    logic [7:0]  char_fifo [QUEUE_DEPTH];
    int          head_q;
    int          count_q;

    scan_result_t expected_scans [$];
    int  errors = 0;
    int  n_items = 0;
    int  n_results = 0;
    int  n_steps = 0;
    int  n_drops = 0;
    int  burst_left = 0;
    int  idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = MODE_TICK;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PERIOD;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    task automatic reset_model();
        period_q = PERIOD_RESET;
        low_cols_q = 1'b1;
        for (int r = 0; r < NROWS; r++)
        begin
            user_rows[r] = '0;
            text_rows[r] = '0;
        end
        scan_q = '0;
        tick_q = '0;
        glyph_col_q = '0;
        col_lit_q = 1'b0;
        head_q = 0;
        count_q = 0;
    endtask

    task automatic shift_text();
        logic [7:0] ch;
        logic [6:0] gi;
        logic [7:0] bits;
        logic       skip;
        n_steps++;
        for (int pass = 0; pass < 2; pass++)
        begin
            skip = 1'b0;
            ch = (count_q != 0) ? char_fifo[head_q] : 8'd0;
            gi = (ch >= 8'h20 && ch < 8'h7F) ? 7'(ch - 8'h20) : 7'd0;
            if (glyph_col_q >= GAP_COL && !col_lit_q)
                skip = 1'b1;
            else
            begin
                col_lit_q = 1'b0;
                bits = (glyph_col_q < GAP_COL) ? FONT[gi][39 - 8 * glyph_col_q -: 8] : 8'd0;
                for (int r = 0; r < NROWS; r++)
                begin
                    text_rows[r] = text_rows[r] >> 1;
                    if (bits[r])
                    begin
                        text_rows[r][15] = 1'b1;
                        col_lit_q = 1'b1;
                    end
                end
            end
            if (count_q != 0)
            begin
                glyph_col_q = (glyph_col_q >= GAP_COL) ? 3'd0 : glyph_col_q + 3'd1;
                if (glyph_col_q == 0)
                begin
                    head_q = (head_q + 1) % QUEUE_DEPTH;
                    count_q--;
                end
            end
            if (!skip)
                break;
        end
    endtask

    task automatic predict_scan(input logic [1:0] mode, input logic [3:0] row_raw,
                                input logic [4:0] col_raw, input logic [7:0] ch);
        scan_result_t res;
        int rp;
        int cp;
        res = '0;
        res.column_drive = 16'hFFFF;
        rp = row_raw[3] ? int'(row_raw) - 16 : int'(row_raw);
        cp = col_raw[4] ? int'(col_raw) - 32 : int'(col_raw);
        case (mode)
            MODE_TICK:
            begin
                scan_q = (scan_q + 3'd1) % NROWS;
                res.row_select = 5'(1 << scan_q);
                res.column_drive = ~(user_rows[scan_q] ^ text_rows[scan_q]);
                if (!low_cols_q)
                    res.column_drive[7:0] = 8'hFF;
                tick_q = tick_q + 16'd1;
                if (tick_q == period_q)
                begin
                    tick_q = '0;
                    shift_text();
                end
            end
            MODE_SET, MODE_CLEAR:
                for (int r = 0; r < NROWS; r++)
                    for (int c = 0; c < NCOLS; c++)
                        if ((rp == -1 || rp == r) && (cp == -1 || cp == c))
                            user_rows[r][c] = (mode == MODE_SET);
            default:
                if (ch != 0)
                begin
                    if (count_q >= QUEUE_DEPTH)
                    begin
                        res.overflow = 1'b1;
                        n_drops++;
                    end
                    else
                    begin
                        char_fifo[(head_q + count_q) % QUEUE_DEPTH] = ch;
                        count_q++;
                    end
                end
        endcase
        res.low_byte_valid = low_cols_q;
        res.text_empty = (count_q == 0);
        expected_scans.push_back(res);
    endtask

    // Sender works in bursts; valid drops only between bursts.
    task automatic send_item(input logic [1:0] mode, input logic [3:0] row_raw,
                             input logic [4:0] col_raw, input logic [7:0] ch);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {7'd0, ch, col_raw, row_raw};
        do
            @(posedge clk);
        while (!s_axis_tready);
        n_items++;
        predict_scan(mode, row_raw, col_raw, ch);
    endtask

    task automatic write_reg(input logic index, input logic [15:0] value);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        wait (expected_scans.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == CFG_PERIOD)
            period_q = value;
        else
            low_cols_q = value[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(MODE_TICK, 4'($urandom), 5'($urandom), 8'($urandom));
    endtask

    task automatic test_pixel_edits();
        send_item(MODE_SET, 4'hF, 5'h1F, 8'h00);
        send_ticks(2);
        send_item(MODE_CLEAR, 4'd2, 5'h1F, 8'hFF);
        send_item(MODE_CLEAR, 4'hF, 5'd0, 8'h00);
        send_item(MODE_CLEAR, 4'd0, 5'd15, 8'h00);
        send_item(MODE_SET, 4'd5, 5'd3, 8'h00);   // row out of range
        send_item(MODE_SET, 4'hE, 5'd3, 8'h00);   // negative row other than all
        send_item(MODE_CLEAR, 4'd1, 5'd16, 8'h00); // column out of range
        send_item(MODE_CLEAR, 4'd1, 5'h1E, 8'h00);
        send_item(MODE_SET, 4'd4, 5'd15, 8'h00);
        send_ticks(5);
        send_item(MODE_CLEAR, 4'hF, 5'h1F, 8'h00);
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_LOWCOL, 16'h0000);
        send_item(MODE_SET, 4'd3, 5'h1F, 8'h00);
        send_ticks(5);
        write_reg(CFG_LOWCOL, 16'hFFFF);
        send_ticks(5);
        write_reg(CFG_PERIOD, 16'd0);
        send_ticks(3);
        write_reg(CFG_PERIOD, 16'hFFFF);
        send_ticks(3);
        write_reg(CFG_PERIOD, 16'd1000);
        send_ticks(10);
        // The count is now above the new period and has to wrap.
        write_reg(CFG_PERIOD, 16'd3);
        send_ticks(4);
        send_item(MODE_CLEAR, 4'hF, 5'h1F, 8'h00);
    endtask

    task automatic test_text_queue();
        write_reg(CFG_PERIOD, 16'd1);
        // Nonzero codes without a glyph still take a full slot; a zero code is not queued.
        send_item(MODE_APPEND, 4'd0, 5'd0, 8'h41);
        send_item(MODE_APPEND, 4'd0, 5'd0, 8'h00);
        send_item(MODE_APPEND, 4'd0, 5'd0, 8'h1F);
        send_item(MODE_APPEND, 4'd0, 5'd0, 8'h20);
        send_item(MODE_APPEND, 4'd0, 5'd0, 8'h7E);
        send_item(MODE_APPEND, 4'd0, 5'd0, 8'h7F);
        send_item(MODE_APPEND, 4'd0, 5'd0, 8'hFF);
        send_ticks(50);
        for (int i = 0; i < QUEUE_DEPTH + 2; i++)
            send_item(MODE_APPEND, 4'($urandom), 5'($urandom), 8'($urandom_range(1, 255)));
        send_item(MODE_APPEND, 4'd0, 5'd0, 8'h00);
        send_ticks(20);
    endtask

    task automatic test_random(input int n_phases, input int per_phase);
        int sel;
        logic [3:0] row_raw;
        logic [4:0] col_raw;
        logic [7:0] ch;
        for (int p = 0; p < n_phases; p++)
        begin
            case (p % 4)
                0: write_reg(CFG_PERIOD, 16'd1);
                1: write_reg(CFG_PERIOD, 16'($urandom_range(2, 4)));
                2: write_reg(CFG_PERIOD, 16'd2);
                default: write_reg(CFG_PERIOD, 16'($urandom_range(1, 9)));
            endcase
            write_reg(CFG_LOWCOL, 16'($urandom_range(0, 1)));
            for (int i = 0; i < per_phase; i++)
            begin
                sel = $urandom_range(0, 99);
                if ($urandom_range(0, 3) == 0)
                begin
                    row_raw = 4'($urandom);
                    col_raw = 5'($urandom);
                end
                else
                begin
                    row_raw = ($urandom_range(0, 2) == 0) ? 4'hF : 4'($urandom_range(0, 4));
                    col_raw = ($urandom_range(0, 2) == 0) ? 5'h1F : 5'($urandom_range(0, 15));
                end
                ch = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(8'h20, 8'h7E));
                if (sel < 60)
                    send_item(MODE_TICK, row_raw, col_raw, ch);
                else if (sel < 72)
                    send_item(MODE_SET, row_raw, col_raw, ch);
                else if (sel < 84)
                    send_item(MODE_CLEAR, row_raw, col_raw, ch);
                else
                    send_item(MODE_APPEND, row_raw, col_raw, ch);
            end
        end
    endtask

    // Receiver stalls on a rotating pattern that is redrawn now and then.
    initial
    begin
        logic [15:0] pattern;
        pattern = 16'hFFFF;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 63) == 0)
                pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom) | 16'h0101;
            m_axis_tready <= pattern[0];
            pattern = {pattern[0], pattern[15:1]};
        end
    end

    always @(posedge clk)
    begin
        scan_result_t got;
        scan_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.row_select = m_axis_tdata[4:0];
            got.column_drive = m_axis_tdata[20:5];
            got.low_byte_valid = m_axis_tuser[0];
            got.text_empty = m_axis_tuser[1];
            got.overflow = m_axis_tuser[2];
            n_results++;
            if (expected_scans.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction, actual %p", $time, got);
            end
            else
            begin
                want = expected_scans.pop_front();
                if (got.row_select !== want.row_select)
                    $display("%0t: row_select expected %h actual %h", $time,
                             want.row_select, got.row_select);
                if (got.column_drive !== want.column_drive)
                    $display("%0t: column_drive expected %h actual %h", $time,
                             want.column_drive, got.column_drive);
                if (got.low_byte_valid !== want.low_byte_valid)
                    $display("%0t: low_byte_valid expected %b actual %b", $time,
                             want.low_byte_valid, got.low_byte_valid);
                if (got.text_empty !== want.text_empty)
                    $display("%0t: text_empty expected %b actual %b", $time,
                             want.text_empty, got.text_empty);
                if (got.overflow !== want.overflow)
                    $display("%0t: overflow expected %b actual %b", $time,
                             want.overflow, got.overflow);
                if (got !== want)
                    errors++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout with %0d transactions outstanding", expected_scans.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        reset_model();
        wait (rst_n === 1'b1);
        test_pixel_edits();
        test_register_extremes();
        test_text_queue();
        test_random(5, 90);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (expected_scans.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d items and %0d results, %0d scroll steps, %0d dropped characters.",
                 n_items, n_results, n_steps, n_drops);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
rtl/core/lmts_pkg.sv
rtl/core/lmts_ctrl.sv
rtl/core/lmts_datapath.sv
rtl/core/led_matrix_text_scroller_unit.sv
rtl/core/lmts_checker.sv
bench/led_matrix_text_scroller_unit_tb.sv
